// ----- hdl/htc_pkg.sv -----
// Shared types, constants and weight functions for the hole template correlator.
// Used by htc_accum, htc_engine and hole_template_correlator_top; no dependencies.
package htc_pkg;

    // Default candidate shape.
    localparam int RING_POINTS_DEF  = 11;
    localparam int TOTAL_POINTS_DEF = 16;

    // Template weights.
    localparam logic [6:0] W_RING   = 7'd70;
    localparam logic [6:0] W_CENTER = 7'd20;
    localparam logic [6:0] W_INNER  = 7'd40;

    // Field widths.
    localparam int PIX_W   = 8;
    localparam int THR_W   = 17;
    localparam int LIM_W   = 14;
    localparam int SCORE_W = 18;
    localparam int MAG_W   = 17;

    // Accumulator widths, sized for the largest candidate of 32 points.
    localparam int SUM_W = 13;
    localparam int SQ_W  = 21;
    localparam int WS_W  = 20;

    // Datapath widths of the shared unit.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 27;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int M_W     = 50;
    localparam int REM_W   = M_W + 1;
    localparam int TQ_W    = 33;
    localparam int VAR_W   = 28;
    localparam int S_W     = 27;

    // Register map, selected by paddr[2].
    localparam logic REG_MATCH_THRESHOLD = 1'b0;
    localparam logic REG_VARIANCE_LIMIT  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_VMUL, S_VCMP, S_CSQ, S_CMB, S_CS, S_CP, S_CM,
        S_DIV, S_SQRT, S_P1, S_P2, S_DONE
    } t_state;

    // Accumulator events, registered and seen in the cycle after the sample that causes them.
    typedef struct packed {
        logic ring_hit;
        logic last_hit;
    } t_acc_status;

    typedef struct packed {
        logic                      ring_variance_ok_2;
        logic                      ring_variance_ok_1;
        logic                      ring_variance_ok_0;
        logic signed [SCORE_W-1:0] green_score;
        logic signed [SCORE_W-1:0] score_product;
        logic                      is_hole;
    } t_result;

    typedef logic [2:0][SUM_W-1:0] t_sum_arr;
    typedef logic [2:0][SQ_W-1:0]  t_sq_arr;
    typedef logic [2:0][WS_W-1:0]  t_ws_arr;

    // Weight of sample idx.
    function automatic logic [6:0] weight_of(input int idx, input int ring);
        logic [6:0] w;
        if (idx < ring)       w = W_RING;
        else if (idx == ring) w = W_CENTER;
        else                  w = W_INNER;
        return w;
    endfunction

    // Sum of weights over a candidate, elaboration time only.
    function automatic int weight_sum(input int ring, input int total);
        int s;
        s = 0;
        for (int i = 0; i < total; i++) s += int'(weight_of(i, ring));
        return s;
    endfunction

    // Sum of squared weights over a candidate, elaboration time only.
    function automatic int weight_sq_sum(input int ring, input int total);
        int s;
        s = 0;
        for (int i = 0; i < total; i++) s += int'(weight_of(i, ring)) * int'(weight_of(i, ring));
        return s;
    endfunction

endpackage

// ----- hdl/htc_accum.sv -----
// Per-channel running sums, square sums and weighted sums with the sample counter.
// Depends on htc_pkg.
module htc_accum #(
    parameter int RING_POINTS  = htc_pkg::RING_POINTS_DEF,
    parameter int TOTAL_POINTS = htc_pkg::TOTAL_POINTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [3*htc_pkg::PIX_W-1:0] i_pixel,  // red, green, blue from bit 0 up
    input  logic                     i_clear,
    output htc_pkg::t_acc_status     o_status,
    output htc_pkg::t_sum_arr        o_sum,
    output htc_pkg::t_sq_arr         o_sq,
    output htc_pkg::t_ws_arr         o_ws
);
    import htc_pkg::*;

    localparam int IDX_W = $clog2(TOTAL_POINTS + 1);
    localparam logic [IDX_W-1:0] RING_IDX  = IDX_W'(RING_POINTS);
    localparam logic [IDX_W-1:0] TOTAL_IDX = IDX_W'(TOTAL_POINTS);

    logic [IDX_W-1:0] r_idx, n_idx;
    t_sum_arr         r_sum;
    t_sq_arr          r_sq;
    t_ws_arr          r_ws;
    t_acc_status      r_status;
    logic [6:0]       weight;

    assign weight = weight_of(int'(r_idx), RING_POINTS);
    assign n_idx  = r_idx + 1'b1;

    // Counter and event flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_idx    <= '0;
            r_status <= '0;
        end else begin
            r_status.ring_hit <= i_accept && (n_idx == RING_IDX);
            r_status.last_hit <= i_accept && (n_idx == TOTAL_IDX);
            if (i_accept) r_idx <= n_idx;
        end
    end

    // Running sums, one update per accepted sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sum <= '0;
            r_sq  <= '0;
            r_ws  <= '0;
        end else if (i_accept) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sum[c] + SUM_W'(i_pixel[c*PIX_W +: PIX_W]);
                r_sq[c]  <= r_sq[c] + SQ_W'({8'd0, i_pixel[c*PIX_W +: PIX_W]}
                                            * {8'd0, i_pixel[c*PIX_W +: PIX_W]});
                r_ws[c]  <= r_ws[c] + WS_W'({7'd0, i_pixel[c*PIX_W +: PIX_W]} * {8'd0, weight});
            end
        end
    end

    assign o_status = r_status;
    assign o_sum    = r_sum;
    assign o_sq     = r_sq;
    assign o_ws     = r_ws;

endmodule

// ----- hdl/htc_engine.sv -----
// Sequencer and shared multiply/divide/root datapath: ring variance check,
// per-channel correlation and score product. Depends on htc_pkg.
module htc_engine #(
    parameter int RING_POINTS  = htc_pkg::RING_POINTS_DEF,
    parameter int TOTAL_POINTS = htc_pkg::TOTAL_POINTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  htc_pkg::t_acc_status        i_status,
    input  htc_pkg::t_sum_arr           i_sum,
    input  htc_pkg::t_sq_arr            i_sq,
    input  htc_pkg::t_ws_arr            i_ws,
    input  logic [htc_pkg::THR_W-1:0]   i_threshold,
    input  logic [htc_pkg::LIM_W-1:0]   i_limit,
    input  logic                        i_out_free,
    output logic                        o_ready,
    output logic                        o_emit,
    output logic                        o_clear,
    output htc_pkg::t_result            o_result
);
    import htc_pkg::*;

    localparam int SA  = weight_sum(RING_POINTS, TOTAL_POINTS);
    localparam int SA2 = weight_sq_sum(RING_POINTS, TOTAL_POINTS);
    localparam int MA  = TOTAL_POINTS * SA2 - SA * SA;
    localparam logic        MA_POS = (MA > 0);
    localparam logic [22:0] MA_K   = 23'(MA);
    localparam logic [11:0] SA_K   = 12'(SA);
    localparam logic [5:0]  TOT_K  = 6'(TOTAL_POINTS);
    localparam logic [4:0]  RING_K = 5'(RING_POINTS);
    localparam logic [8:0]  RING_SQ_K = 9'(RING_POINTS * RING_POINTS);

    t_state               r_state, n_state;
    logic [1:0]           r_ch;
    logic                 r_pend_last;
    logic [2:0]           r_quiet;
    logic [5:0]           r_cnt;
    logic [TQ_W-1:0]      r_tmp;
    logic signed [VAR_W-1:0] r_mb;
    logic signed [S_W-1:0]   r_s;
    logic [M_W-1:0]       r_p;
    logic [M_W-1:0]       r_m;
    logic [REM_W-1:0]     r_rem;
    logic [TQ_W-1:0]      r_q;
    logic [MAG_W-1:0]     r_root;
    logic [2:0][MAG_W-1:0] r_mag;
    logic [2:0]           r_neg;
    t_result              r_res;

    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [MUL_P_W-1:0]   mul_p;
    logic [MAG_W-1:0]     trial;
    logic                 root_ok;
    logic                 div_ge;
    logic [M_W-1:0]       div_diff;
    logic signed [VAR_W-1:0] var_lhs, var_rhs;
    logic [S_W-2:0]       s_abs;
    logic                 zero_den;
    logic                 last_ch;
    logic [MAG_W-1:0]     prod_mag;
    logic                 prod_neg;
    logic signed [SCORE_W-1:0] score, green;
    logic signed [SCORE_W-1:0] thr_s;

    // Shared multiplier operand selection.
    assign trial = r_root | (MAG_W'(1) << r_cnt[4:0]);
    assign s_abs = r_s[S_W-1] ? (S_W-1)'(-r_s) : r_s[S_W-2:0];
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_VMUL, S_CSQ: begin
                mul_a = MUL_A_W'(i_sum[r_ch]);
                mul_b = MUL_B_W'(i_sum[r_ch]);
            end
            S_CP: begin
                mul_a = MUL_A_W'(s_abs);
                mul_b = MUL_B_W'(s_abs);
            end
            S_CM: begin
                mul_a = MUL_A_W'(r_mb[MUL_B_W-1:0]);
                mul_b = MUL_B_W'(MA_K);
            end
            S_SQRT: begin
                mul_a = MUL_A_W'(trial);
                mul_b = MUL_B_W'(trial);
            end
            S_P1: begin
                mul_a = MUL_A_W'(r_mag[0]);
                mul_b = MUL_B_W'(r_mag[1]);
            end
            S_P2: begin
                mul_a = r_tmp;
                mul_b = MUL_B_W'(r_mag[2]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Compare and subtract terms.
    assign root_ok  = (mul_p[TQ_W:0] <= {1'b0, r_q});
    assign div_ge   = (r_rem >= {1'b0, r_m});
    assign div_diff = div_ge ? M_W'(r_rem - {1'b0, r_m}) : r_rem[M_W-1:0];
    assign var_lhs  = $signed(VAR_W'(RING_K) * VAR_W'(i_sq[r_ch])) - $signed(VAR_W'(r_tmp));
    assign var_rhs  = $signed(VAR_W'(RING_SQ_K) * VAR_W'(i_limit));
    assign zero_den = !MA_POS || (r_mb <= 0);
    assign last_ch  = (r_ch == 2'd2);

    // Score product and pass test.
    assign prod_mag = MAG_W'(mul_p >> 32);
    assign prod_neg = r_neg[0] ^ r_neg[1] ^ r_neg[2];
    assign score    = prod_neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
    assign green    = r_neg[1] ? -$signed({1'b0, r_mag[1]}) : $signed({1'b0, r_mag[1]});
    assign thr_s    = $signed({1'b0, i_threshold});

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_status.ring_hit)      n_state = S_VMUL;
                else if (i_status.last_hit) n_state = S_CSQ;
            end
            S_VMUL: n_state = S_VCMP;
            S_VCMP: begin
                if (!last_ch)         n_state = S_VMUL;
                else if (r_pend_last) n_state = S_CSQ;
                else                  n_state = S_IDLE;
            end
            S_CSQ: n_state = S_CMB;
            S_CMB: n_state = S_CS;
            S_CS:  n_state = S_CP;
            S_CP:  n_state = S_CM;
            S_CM: begin
                if (!zero_den)   n_state = S_DIV;
                else if (last_ch) n_state = S_P1;
                else             n_state = S_CSQ;
            end
            S_DIV:  if (r_cnt == 6'd32) n_state = S_SQRT;
            S_SQRT: begin
                if (r_cnt == 6'd0) n_state = last_ch ? S_P1 : S_CSQ;
            end
            S_P1:   n_state = S_P2;
            S_P2:   n_state = S_DONE;
            S_DONE: if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_ready = (r_state == S_IDLE) && !i_status.ring_hit && !i_status.last_hit;
        o_emit  = (r_state == S_DONE) && i_out_free;
        o_clear = o_emit;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_pend_last <= 1'b0;
            r_quiet     <= '0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_ch        <= '0;
                    r_pend_last <= i_status.last_hit;
                end
                S_VCMP: begin
                    r_quiet[r_ch] <= (var_lhs < var_rhs);
                    r_ch          <= last_ch ? 2'd0 : r_ch + 1'b1;
                end
                S_CM: begin
                    r_cnt <= '0;
                    if (zero_den) r_ch <= r_ch + 1'b1;
                end
                S_DIV:  r_cnt <= (r_cnt == 6'd32) ? 6'd16 : r_cnt + 1'b1;
                S_SQRT: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 6'd0) r_ch <= r_ch + 1'b1;
                end
                S_DONE: if (i_out_free) r_quiet <= '0;
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_VMUL, S_CSQ: r_tmp <= mul_p[TQ_W-1:0];
            S_CMB: r_mb <= $signed(VAR_W'(TOT_K) * VAR_W'(i_sq[r_ch])) - $signed(VAR_W'(r_tmp));
            S_CS:  r_s  <= $signed(S_W'(TOT_K) * S_W'(i_ws[r_ch]))
                           - $signed(S_W'(SA_K) * S_W'(i_sum[r_ch]));
            S_CP:  r_p  <= mul_p[M_W-1:0];
            S_CM: begin
                r_m    <= mul_p[M_W-1:0];
                r_rem  <= {1'b0, r_p};
                r_q    <= '0;
                r_root <= '0;
                r_neg[r_ch] <= r_s[S_W-1];
                if (zero_den) r_mag[r_ch] <= '0;
            end
            S_DIV: begin
                r_q   <= {r_q[TQ_W-2:0], div_ge};
                r_rem <= {div_diff, 1'b0};
            end
            S_SQRT: begin
                if (root_ok) r_root <= trial;
                if (r_cnt == 6'd0) r_mag[r_ch] <= root_ok ? trial : r_root;
            end
            S_P1: r_tmp <= mul_p[TQ_W-1:0];
            S_P2: begin
                r_res.is_hole            <= (green > thr_s) && (score > thr_s) && (&r_quiet);
                r_res.score_product      <= score;
                r_res.green_score        <= green;
                r_res.ring_variance_ok_0 <= r_quiet[0];
                r_res.ring_variance_ok_1 <= r_quiet[1];
                r_res.ring_variance_ok_2 <= r_quiet[2];
            end
            default: ;
        endcase
    end

    assign o_result = r_res;

    // The division remainder stays below twice the denominator.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {r_m, 1'b0}))
        else $error("division remainder out of range");

    // The partial root never exceeds the root of the quotient.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (({17'd0, r_root} * {17'd0, r_root}) <= {1'b0, r_q}))
        else $error("partial root too large");

    // Channel magnitudes stay within one in Q.16 before the product.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P1) |-> (r_mag[0] <= 17'd65536 && r_mag[1] <= 17'd65536
                               && r_mag[2] <= 17'd65536))
        else $error("channel score magnitude above one");

    // After a result leaves, the sequencer is idle and the flags are cleared.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_state == S_IDLE) && (r_quiet == 3'd0))
        else $error("sequencer not idle after result");

endmodule

// ----- hdl/hole_template_correlator_top.sv -----
// Top level of the hole template correlator: stream ports, register port and result register.
// Depends on htc_pkg, htc_accum and htc_engine.
//
// Each candidate is a run of TOTAL_POINTS RGB samples, one per request: the first
// RING_POINTS are ring points, then the centre, then inner points. Samples are taken one
// per cycle; after the sample that closes the ring the input stalls while the shared
// multiplier checks the ring variance of the three channels. After the last sample
// the input stalls while the same multiplier, a 33-step restoring divider and a 17-step
// root search score each channel one after another; a channel with zero variance skips
// the divider and the root search. The result then sits in an output register, and the
// next candidate's samples are taken meanwhile; a new result waits until the previous
// one has gone, and no samples are taken while it waits.
module hole_template_correlator_top #(
    parameter int RING_POINTS  = htc_pkg::RING_POINTS_DEF,
    parameter int TOTAL_POINTS = htc_pkg::TOTAL_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // sample_red, sample_green, sample_blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // is_hole, score_product, green_score, ring_variance_ok
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import htc_pkg::*;

    logic [THR_W-1:0] r_threshold;
    logic [LIM_W-1:0] r_limit;
    logic             r_out_valid;
    t_result          r_out;
    t_acc_status      status;
    t_sum_arr         sums;
    t_sq_arr          sqs;
    t_ws_arr          wss;
    t_result          result;
    logic             accept, out_free, emit, clear, ready;

    // Register port.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_W'(45875);
            r_limit     <= LIM_W'(1024);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_MATCH_THRESHOLD: r_threshold <= pwdata[THR_W-1:0];
                REG_VARIANCE_LIMIT:  r_limit     <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (paddr[2])
            REG_MATCH_THRESHOLD: prdata = 32'(r_threshold);
            REG_VARIANCE_LIMIT:  prdata = 32'(r_limit);
            default:             prdata = '0;
        endcase
    end

    assign s_axis_tready = ready;
    assign accept        = s_axis_tvalid && ready;

    htc_accum #(
        .RING_POINTS (RING_POINTS),
        .TOTAL_POINTS(TOTAL_POINTS)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_pixel (s_axis_tdata),
        .i_clear (clear),
        .o_status(status),
        .o_sum   (sums),
        .o_sq    (sqs),
        .o_ws    (wss)
    );

    htc_engine #(
        .RING_POINTS (RING_POINTS),
        .TOTAL_POINTS(TOTAL_POINTS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (status),
        .i_sum      (sums),
        .i_sq       (sqs),
        .i_ws       (wss),
        .i_threshold(r_threshold),
        .i_limit    (r_limit),
        .i_out_free (out_free),
        .o_ready    (ready),
        .o_emit     (emit),
        .o_clear    (clear),
        .o_result   (result)
    );

    // Output register.
    assign out_free = !r_out_valid || m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (emit) r_out <= result;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule
